// ===== rtl/core/bstpq_pkg.sv =====
package bstpq_pkg;

  localparam int REQ_W    = 2;
  localparam int KEY_W    = 24;
  localparam int COST_W   = 16;
  localparam int NODE_W   = 16;
  localparam int EDGE_W   = 18;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int PAY_W    = COST_W + NODE_W + EDGE_W;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PULL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [EDGE_W-1:0] NO_EDGE = '1;

  typedef struct packed {
    logic node_rd;
    logic node_wr;
    logic pay_rd;
    logic pay_wr;
  } store_ctl_t;

endpackage

// ===== rtl/core/bstpq_if.sv =====
interface bstpq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [bstpq_pkg::REQ_W-1:0]           req_type;
  logic [bstpq_pkg::KEY_W-1:0]           priority_key;
  logic [bstpq_pkg::COST_W-1:0]          path_cost;
  logic [bstpq_pkg::NODE_W-1:0]          node_index;
  logic signed [bstpq_pkg::EDGE_W-1:0]   arrival_edge;

  modport source (output valid, req_type, priority_key, path_cost, node_index, arrival_edge,
                  input ready);
  modport sink (input valid, req_type, priority_key, path_cost, node_index, arrival_edge,
                output ready);
endinterface

interface bstpq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [bstpq_pkg::STATUS_W-1:0]        status;
  logic [bstpq_pkg::COST_W-1:0]          out_cost;
  logic [bstpq_pkg::NODE_W-1:0]          out_node;
  logic signed [bstpq_pkg::EDGE_W-1:0]   out_edge;
  logic [bstpq_pkg::COUNT_W-1:0]         live_count;

  modport source (output valid, status, out_cost, out_node, out_edge, live_count,
                  input ready);
  modport sink (input valid, status, out_cost, out_node, out_edge, live_count,
                output ready);
endinterface

// ===== rtl/core/bstpq_store.sv =====
module bstpq_store #(
  parameter int CAPACITY = 1024,
  parameter int SLOT_W   = 10,
  parameter int REC_W    = 46
) (
  input  logic                          clk,
  input  bstpq_pkg::store_ctl_t         ctl,
  input  logic [SLOT_W-1:0]             node_raddr,
  input  logic [SLOT_W-1:0]             node_waddr,
  input  logic [REC_W-1:0]              node_wdata,
  output logic [REC_W-1:0]              node_rdata,
  input  logic [SLOT_W-1:0]             pay_raddr,
  input  logic [SLOT_W-1:0]             pay_waddr,
  input  logic [bstpq_pkg::PAY_W-1:0]   pay_wdata,
  output logic [bstpq_pkg::PAY_W-1:0]   pay_rdata
);
  import bstpq_pkg::*;

  // key and child links per slot
  logic [REC_W-1:0] node_mem [CAPACITY];
  // cost, node and edge per slot
  logic [PAY_W-1:0] pay_mem [CAPACITY];

  logic [REC_W-1:0] node_rdata_r;
  logic [PAY_W-1:0] pay_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.node_wr) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (ctl.node_rd) begin
      node_rdata_r <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pay_wr) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (ctl.pay_rd) begin
      pay_rdata_r <= pay_mem[pay_raddr];
    end
  end

  assign node_rdata = node_rdata_r;
  assign pay_rdata  = pay_rdata_r;

endmodule

// ===== rtl/core/bstpq_ctrl.sv =====
module bstpq_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int SLOT_W   = 10,
  parameter int CNT_W    = 11,
  parameter int REC_W    = 46
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bstpq_in_if.sink                      in_ch,
  bstpq_out_if.source                   out_ch,
  output bstpq_pkg::store_ctl_t         ctl,
  output logic [SLOT_W-1:0]             node_raddr,
  output logic [SLOT_W-1:0]             node_waddr,
  output logic [REC_W-1:0]              node_wdata,
  input  logic [REC_W-1:0]              node_rdata,
  output logic [SLOT_W-1:0]             pay_raddr,
  output logic [SLOT_W-1:0]             pay_waddr,
  output logic [bstpq_pkg::PAY_W-1:0]   pay_wdata,
  input  logic [bstpq_pkg::PAY_W-1:0]   pay_rdata
);
  import bstpq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_LINK, S_PAY, S_DONE} state_t;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // record layout: {key, has_left, left, has_right, right}
  logic [KEY_W-1:0]  nd_key;
  logic              nd_hl;
  logic [SLOT_W-1:0] nd_left;
  logic              nd_hr;
  logic [SLOT_W-1:0] nd_right;

  assign nd_key   = node_rdata[REC_W-1 -: KEY_W];
  assign nd_hl    = node_rdata[2*SLOT_W+1];
  assign nd_left  = node_rdata[SLOT_W+1 +: SLOT_W];
  assign nd_hr    = node_rdata[SLOT_W];
  assign nd_right = node_rdata[SLOT_W-1:0];

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]    nf_r, nf_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOT_W-1:0]   prev_r, prev_nxt;
  logic [REC_W-1:0]    prev_rec_r, prev_rec_nxt;
  logic                at_root_r, at_root_nxt;
  logic                op_pull_r, op_pull_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [PAY_W-1:0]    pay_r, pay_nxt;

  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [COST_W-1:0]       res_cost_r, res_cost_nxt;
  logic [NODE_W-1:0]       res_node_r, res_node_nxt;
  logic signed [EDGE_W-1:0] res_edge_r, res_edge_nxt;

  logic [STATUS_W-1:0]     o_status_r, o_status_nxt;
  logic [COST_W-1:0]       o_cost_r, o_cost_nxt;
  logic [NODE_W-1:0]       o_node_r, o_node_nxt;
  logic signed [EDGE_W-1:0] o_edge_r, o_edge_nxt;
  logic [COUNT_W-1:0]      o_count_r, o_count_nxt;

  logic [SLOT_W-1:0] wslot;
  logic              go_right;

  assign wslot    = nf_r[SLOT_W-1:0];
  assign go_right = key_r > nd_key;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = o_status_r;
  assign out_ch.out_cost   = o_cost_r;
  assign out_ch.out_node   = o_node_r;
  assign out_ch.out_edge   = o_edge_r;
  assign out_ch.live_count = o_count_r;

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    nf_nxt         = nf_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_rec_nxt   = prev_rec_r;
    at_root_nxt    = at_root_r;
    op_pull_nxt    = op_pull_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    res_status_nxt = res_status_r;
    res_cost_nxt   = res_cost_r;
    res_node_nxt   = res_node_r;
    res_edge_nxt   = res_edge_r;
    o_status_nxt   = o_status_r;
    o_cost_nxt     = o_cost_r;
    o_node_nxt     = o_node_r;
    o_edge_nxt     = o_edge_r;
    o_count_nxt    = o_count_r;
    ctl            = '0;
    node_raddr     = cur_r;
    node_waddr     = cur_r;
    node_wdata     = prev_rec_r;
    pay_raddr      = cur_r;
    pay_waddr      = wslot;
    pay_wdata      = pay_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_status_nxt = ST_OK;
          res_cost_nxt   = '0;
          res_node_nxt   = '0;
          res_edge_nxt   = NO_EDGE;
          key_nxt        = in_ch.priority_key;
          pay_nxt        = {in_ch.path_cost, in_ch.node_index, in_ch.arrival_edge};
          state_nxt      = S_DONE;
          case (in_ch.req_type)
            REQ_INSERT: begin
              if (nf_r == CAP_CNT) begin
                res_status_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                ctl.node_wr = 1'b1;
                ctl.pay_wr  = 1'b1;
                node_waddr  = root_r;
                node_wdata  = {in_ch.priority_key, {(2*SLOT_W+2){1'b0}}};
                pay_waddr   = root_r;
                pay_wdata   = {in_ch.path_cost, in_ch.node_index, in_ch.arrival_edge};
                nf_nxt      = nf_r + CNT_W'(1);
                cnt_nxt     = cnt_r + CNT_W'(1);
              end else begin
                ctl.node_rd = 1'b1;
                node_raddr  = root_r;
                cur_nxt     = root_r;
                op_pull_nxt = 1'b0;
                state_nxt   = S_WALK;
              end
            end
            REQ_PULL: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                ctl.node_rd = 1'b1;
                node_raddr  = root_r;
                cur_nxt     = root_r;
                at_root_nxt = 1'b1;
                op_pull_nxt = 1'b1;
                state_nxt   = S_WALK;
              end
            end
            REQ_CLEAR: begin
              root_nxt = '0;
              nf_nxt   = '0;
              cnt_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (op_pull_r) begin
          if (nd_hl) begin
            ctl.node_rd  = 1'b1;
            node_raddr   = nd_left;
            prev_nxt     = cur_r;
            prev_rec_nxt = node_rdata;
            at_root_nxt  = 1'b0;
            cur_nxt      = nd_left;
          end else begin
            // leftmost found: splice its right subtree into its place
            ctl.pay_rd = 1'b1;
            pay_raddr  = cur_r;
            if (at_root_r) begin
              if (nd_hr) begin
                root_nxt = nd_right;
              end
            end else begin
              ctl.node_wr = 1'b1;
              node_waddr  = prev_r;
              node_wdata  = {prev_rec_r[REC_W-1 -: KEY_W], nd_hr, nd_right,
                             prev_rec_r[SLOT_W:0]};
            end
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_PAY;
          end
        end else begin
          if (go_right ? nd_hr : nd_hl) begin
            ctl.node_rd = 1'b1;
            node_raddr  = go_right ? nd_right : nd_left;
            cur_nxt     = go_right ? nd_right : nd_left;
          end else begin
            ctl.node_wr = 1'b1;
            ctl.pay_wr  = 1'b1;
            node_waddr  = wslot;
            node_wdata  = {key_r, {(2*SLOT_W+2){1'b0}}};
            pay_waddr   = wslot;
            pay_wdata   = pay_r;
            if (go_right) begin
              prev_rec_nxt = {nd_key, nd_hl, nd_left, 1'b1, wslot};
            end else begin
              prev_rec_nxt = {nd_key, 1'b1, wslot, nd_hr, nd_right};
            end
            state_nxt = S_LINK;
          end
        end
      end
      S_LINK: begin
        ctl.node_wr = 1'b1;
        node_waddr  = cur_r;
        node_wdata  = prev_rec_r;
        nf_nxt      = nf_r + CNT_W'(1);
        cnt_nxt     = cnt_r + CNT_W'(1);
        state_nxt   = S_DONE;
      end
      S_PAY: begin
        res_cost_nxt = pay_rdata[PAY_W-1 -: COST_W];
        res_node_nxt = pay_rdata[EDGE_W +: NODE_W];
        res_edge_nxt = pay_rdata[EDGE_W-1:0];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_cost_nxt    = res_cost_r;
          o_node_nxt    = res_node_r;
          o_edge_nxt    = res_edge_r;
          o_count_nxt   = COUNT_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_rec_r   <= prev_rec_nxt;
    at_root_r    <= at_root_nxt;
    op_pull_r    <= op_pull_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_cost_r   <= res_cost_nxt;
    res_node_r   <= res_node_nxt;
    res_edge_r   <= res_edge_nxt;
    o_status_r   <= o_status_nxt;
    o_cost_r     <= o_cost_nxt;
    o_node_r     <= o_node_nxt;
    o_edge_r     <= o_edge_nxt;
    o_count_r    <= o_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      nf_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      nf_r        <= nf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cnt_le_nf: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= nf_r)
    else $error("live count exceeds slots handed out");

  a_nf_cap: assert property (@(posedge clk) disable iff (!rst_n) nf_r <= CAP_CNT)
    else $error("write pointer past capacity");

  a_node_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.node_rd && ctl.node_wr))
    else $error("node store read and write in one cycle");

  a_pay_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAY) |-> $past(ctl.pay_rd))
    else $error("payload captured without a read");

endmodule

// ===== rtl/core/bst_priority_queue_core.sv =====
// Open list for a path search, kept as an unbalanced binary search tree.
// in_ch carries one request item: insert (key, cost, node, edge), pull of the
// lowest-key entry, or clear. out_ch returns exactly one result item per
// request: status, pulled payload (zero/zero/-1 when nothing is pulled) and
// the live entry count after the request.
// A clear, a refused request or an insert into an empty queue goes straight to
// S_DONE, which loads the result into the out_ch registers. An insert into a
// non-empty tree walks down in S_WALK and links the new slot in S_LINK; a pull
// walks to the leftmost entry in S_WALK and reads its payload in S_PAY; the walk
// makes one node store read per tree level visited. One request is in work at a
// time; the next is accepted only after S_DONE has loaded the result.
// in_ch.ready is high while the block is idle, also while a previous result
// still waits on out_ch. Slots come from a write pointer that only a clear or
// reset rewinds, but an insert into an empty queue reuses the root slot; an
// insert is refused with full status once CAPACITY inserts followed the last
// clear. Reset empties the queue at once; the node and payload stores are not
// cleared. If out_ch stalls, the finished result waits in the block until the
// output register frees, and no further request is accepted meanwhile.
module bst_priority_queue_core #(
  parameter int CAPACITY = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  bstpq_in_if.sink      in_ch,
  bstpq_out_if.source   out_ch
);
  import bstpq_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int REC_W  = KEY_W + 2 * SLOT_W + 2;

  store_ctl_t        ctl;
  logic [SLOT_W-1:0] node_raddr;
  logic [SLOT_W-1:0] node_waddr;
  logic [REC_W-1:0]  node_wdata;
  logic [REC_W-1:0]  node_rdata;
  logic [SLOT_W-1:0] pay_raddr;
  logic [SLOT_W-1:0] pay_waddr;
  logic [PAY_W-1:0]  pay_wdata;
  logic [PAY_W-1:0]  pay_rdata;

  bstpq_ctrl #(
    .CAPACITY (CAPACITY),
    .SLOT_W   (SLOT_W),
    .CNT_W    (CNT_W),
    .REC_W    (REC_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .ctl        (ctl),
    .node_raddr (node_raddr),
    .node_waddr (node_waddr),
    .node_wdata (node_wdata),
    .node_rdata (node_rdata),
    .pay_raddr  (pay_raddr),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .pay_rdata  (pay_rdata)
  );

  bstpq_store #(
    .CAPACITY (CAPACITY),
    .SLOT_W   (SLOT_W),
    .REC_W    (REC_W)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .node_raddr (node_raddr),
    .node_waddr (node_waddr),
    .node_wdata (node_wdata),
    .node_rdata (node_rdata),
    .pay_raddr  (pay_raddr),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .pay_rdata  (pay_rdata)
  );

endmodule

// ===== bench/bst_priority_queue_core_checker.sv =====
module bst_priority_queue_core_checker #(
  parameter int CAPACITY = 1024
) (
  input  logic  clk,
  input  logic  rst_n,
  bstpq_in_if   in_mon,
  bstpq_out_if  out_mon,
  output int    fail_count,
  output int    pending_count
);
  import bstpq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COST_W-1:0]   cost;
    logic [NODE_W-1:0]   node;
    logic [EDGE_W-1:0]   arr_edge;
    logic [COUNT_W-1:0]  count;
  } pq_result_t;

  logic [KEY_W-1:0]  slot_key    [CAPACITY];
  logic [COST_W-1:0] slot_cost   [CAPACITY];
  logic [NODE_W-1:0] slot_node   [CAPACITY];
  logic [EDGE_W-1:0] slot_edge   [CAPACITY];
  int unsigned       slot_parent [CAPACITY];
  int unsigned       slot_left   [CAPACITY];
  int unsigned       slot_right  [CAPACITY];
  bit                slot_has_parent [CAPACITY];
  bit                slot_has_left   [CAPACITY];
  bit                slot_has_right  [CAPACITY];

  int unsigned tree_root;
  int unsigned write_ptr;
  int unsigned live_entries;

  pq_result_t expected_results[$];
  int         errors = 0;

  function automatic void place_entry(input int unsigned slot, input logic [KEY_W-1:0] key,
                                      input logic [COST_W-1:0] cost,
                                      input logic [NODE_W-1:0] node,
                                      input logic [EDGE_W-1:0] edg, input bit has_par,
                                      input int unsigned par);
    slot_key[slot]        = key;
    slot_cost[slot]       = cost;
    slot_node[slot]       = node;
    slot_edge[slot]       = edg;
    slot_parent[slot]     = par;
    slot_has_parent[slot] = has_par;
    slot_left[slot]       = 0;
    slot_has_left[slot]   = 1'b0;
    slot_right[slot]      = 0;
    slot_has_right[slot]  = 1'b0;
  endfunction

  function automatic pq_result_t serve_request(input logic [REQ_W-1:0] req,
                                               input logic [KEY_W-1:0] key,
                                               input logic [COST_W-1:0] cost,
                                               input logic [NODE_W-1:0] node,
                                               input logic [EDGE_W-1:0] edg);
    pq_result_t  res;
    int unsigned cur;
    int unsigned r;
    int unsigned p;
    bit          done;
    res.status   = ST_OK;
    res.cost     = '0;
    res.node     = '0;
    res.arr_edge = NO_EDGE;
    if (req == REQ_INSERT) begin
      if (write_ptr >= CAPACITY) begin
        res.status = ST_FULL;
      end else if (live_entries == 0) begin
        // empty queue reuses whatever slot the root points at
        place_entry(tree_root, key, cost, node, edg, 1'b0, 0);
        write_ptr++;
        live_entries++;
      end else begin
        cur  = tree_root;
        done = 1'b0;
        for (int steps = 0; steps <= CAPACITY && !done; steps++) begin
          if (key > slot_key[cur]) begin
            if (!slot_has_right[cur]) begin
              place_entry(write_ptr, key, cost, node, edg, 1'b1, cur);
              slot_right[cur]     = write_ptr;
              slot_has_right[cur] = 1'b1;
              done = 1'b1;
            end else begin
              cur = slot_right[cur];
            end
          end else begin
            if (!slot_has_left[cur]) begin
              place_entry(write_ptr, key, cost, node, edg, 1'b1, cur);
              slot_left[cur]     = write_ptr;
              slot_has_left[cur] = 1'b1;
              done = 1'b1;
            end else begin
              cur = slot_left[cur];
            end
          end
        end
        if (done) begin
          write_ptr++;
          live_entries++;
        end else begin
          res.status = ST_FULL;
        end
      end
    end else if (req == REQ_PULL) begin
      if (live_entries == 0) begin
        res.status = ST_EMPTY;
      end else begin
        cur = tree_root;
        for (int steps = 0; steps < CAPACITY && slot_has_left[cur]; steps++)
          cur = slot_left[cur];
        res.cost     = slot_cost[cur];
        res.node     = slot_node[cur];
        res.arr_edge = slot_edge[cur];
        if (!slot_has_parent[cur]) begin
          if (slot_has_right[cur]) begin
            r = slot_right[cur];
            slot_has_parent[r] = 1'b0;
            tree_root = r;
          end
        end else if (slot_has_right[cur]) begin
          r = slot_right[cur];
          p = slot_parent[cur];
          slot_parent[r]     = p;
          slot_has_parent[r] = 1'b1;
          slot_left[p]       = r;
          slot_has_left[p]   = 1'b1;
        end else begin
          slot_has_left[slot_parent[cur]] = 1'b0;
        end
        live_entries--;
      end
    end else if (req == REQ_CLEAR) begin
      tree_root    = 0;
      write_ptr    = 0;
      live_entries = 0;
    end
    res.count = live_entries[COUNT_W-1:0];
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pq_result_t want;
    if (!rst_n) begin
      tree_root    = 0;
      write_ptr    = 0;
      live_entries = 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item: expected none, got status %0h count %0h",
                   $time, out_mon.status, out_mon.live_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_mon.status));
          compare_field("out_cost", 32'(want.cost), 32'(out_mon.out_cost));
          compare_field("out_node", 32'(want.node), 32'(out_mon.out_node));
          compare_field("out_edge", 32'(want.arr_edge), 32'($unsigned(out_mon.out_edge)));
          compare_field("live_count", 32'(want.count), 32'(out_mon.live_count));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(serve_request(in_mon.req_type, in_mon.priority_key,
                                                 in_mon.path_cost, in_mon.node_index,
                                                 in_mon.arrival_edge));
    end
    fail_count    <= errors;
    pending_count <= expected_results.size();
  end

endmodule

// ===== bench/bst_priority_queue_core_test.sv =====
module bst_priority_queue_core_test;
  import bstpq_pkg::*;

  localparam int          CAPACITY    = 1024;
  localparam int          ITEM_TARGET = 1900;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  bstpq_in_if  in_ch ();
  bstpq_out_if out_ch ();

  int fail_count;
  int pending_count;
  int sent = 0;
  int burst_left = 0;
  int ready_left = 0;
  int unsigned cycle_count = 0;
  logic [KEY_W-1:0] key_run;

  bst_priority_queue_core #(.CAPACITY(CAPACITY)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bst_priority_queue_core_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bst_priority_queue_core_test: FAIL");
      $finish;
    end
  end

  // receiver: ready runs and stall runs of random length
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 9) < 6) begin
      out_ch.ready <= 1'b1;
      ready_left = $urandom_range(0, 39);
    end else begin
      out_ch.ready <= 1'b0;
      ready_left = $urandom_range(0, 11);
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom_range(0, 31));
      default: return KEY_W'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [EDGE_W-1:0] rand_edge();
    case ($urandom_range(0, 19))
      0, 1, 2: return NO_EDGE;
      3:       return 18'sd131071;
      default: return EDGE_W'($urandom_range(0, 131071));
    endcase
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                              input logic [COST_W-1:0] cost, input logic [NODE_W-1:0] node,
                              input logic signed [EDGE_W-1:0] edg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.priority_key <= key;
    in_ch.path_cost    <= cost;
    in_ch.node_index   <= node;
    in_ch.arrival_edge <= edg;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (req != REQ_UNUSED)
      sent++;
  endtask

  task automatic rand_send(input logic [REQ_W-1:0] req);
    send_request(req, rand_key(), rand_word(), rand_word(), rand_edge());
  endtask

  task automatic random_request(input int ins_pct, input int pull_pct, input bit ascending);
    int               r;
    logic [KEY_W-1:0] key;
    logic [REQ_W-1:0] req;
    r = $urandom_range(0, 99);
    if (ascending) begin
      key = key_run;
      key_run += KEY_W'($urandom_range(0, 7));
    end else begin
      key = rand_key();
    end
    if (r < ins_pct)
      req = REQ_INSERT;
    else if (r < ins_pct + pull_pct)
      req = REQ_PULL;
    else if (r < ins_pct + pull_pct + 3)
      req = REQ_UNUSED;
    else
      req = REQ_CLEAR;
    send_request(req, key, rand_word(), rand_word(), rand_edge());
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    burst_left = 0;
  endtask

  initial begin
    int mode;
    int len;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_INSERT;
    in_ch.priority_key = '0;
    in_ch.path_cost    = '0;
    in_ch.node_index   = '0;
    in_ch.arrival_edge = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    rand_send(REQ_PULL);
    rand_send(REQ_UNUSED);
    send_request(REQ_INSERT, 24'd5, 16'hFFFF, 16'h0000, NO_EDGE);
    send_request(REQ_INSERT, 24'd10, 16'h0000, 16'hFFFF, 18'sd131071);
    rand_send(REQ_PULL);
    rand_send(REQ_PULL);
    // queue empty with a stale root slot
    send_request(REQ_INSERT, 24'hFFFFFF, 16'h1234, 16'h5678, 18'sd1);
    send_request(REQ_INSERT, 24'h000000, 16'hAAAA, 16'h5555, 18'sd0);
    send_request(REQ_INSERT, 24'hFFFFFF, 16'h5555, 16'hAAAA, NO_EDGE);
    send_request(REQ_INSERT, 24'h000000, 16'h0F0F, 16'hF0F0, 18'sd65536);
    repeat (4) rand_send(REQ_PULL);
    rand_send(REQ_PULL);
    repeat (3) rand_send(REQ_INSERT);
    rand_send(REQ_CLEAR);
    rand_send(REQ_PULL);
    rand_send(REQ_INSERT);
    rand_send(REQ_UNUSED);
    rand_send(REQ_PULL);
    wait_all_results();

    // fill to capacity, then refused inserts, pulls, refused inserts
    rand_send(REQ_CLEAR);
    repeat (CAPACITY) rand_send(REQ_INSERT);
    repeat (6) rand_send(REQ_INSERT);
    repeat (20) rand_send(REQ_PULL);
    repeat (3) rand_send(REQ_INSERT);
    rand_send(REQ_UNUSED);
    rand_send(REQ_CLEAR);

    while (sent < ITEM_TARGET) begin
      mode    = $urandom_range(0, 3);
      len     = $urandom_range(10, 120);
      key_run = KEY_W'($urandom());
      for (int i = 0; i < len; i++) begin
        case (mode)
          0:       random_request(70, 25, 1'b0);
          1:       random_request(50, 45, 1'b0);
          2:       random_request(30, 65, 1'b0);
          default: random_request(75, 20, i < 40);
        endcase
      end
      if ($urandom_range(0, 1) == 0)
        rand_send(REQ_CLEAR);
      if ($urandom_range(0, 3) == 0)
        wait_all_results();
    end

    wait_all_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("bst_priority_queue_core_test: PASS");
    else
      $display("bst_priority_queue_core_test: FAIL");
    $finish;
  end

endmodule

// ===== bst_priority_queue_core.f =====
rtl/core/bstpq_pkg.sv
rtl/core/bstpq_if.sv
rtl/core/bstpq_store.sv
rtl/core/bstpq_ctrl.sv
rtl/core/bst_priority_queue_core.sv
bench/bst_priority_queue_core_checker.sv
bench/bst_priority_queue_core_test.sv
